// File: design/mvsm_pkg.sv
// Shared types, constants and functions for the multi-voice sine and noise
// mixer. Used by every module of the block; depends on nothing.
package mvsm_pkg;

    localparam int VOICE_COUNT_DEF = 64;
    localparam int PHASE_BITS_DEF  = 24;

    localparam int SINE_ENTRIES = 1024;
    localparam int SINE_BITS    = 10;
    localparam int SINE_W       = 15;
    localparam logic [SINE_W-1:0] SINE_FULL = 15'h7FFF;
    localparam int SINE_SHIFT   = 9;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    localparam int RATE_W   = 18;
    localparam int SCALE_W  = 20;
    localparam int SAMPLE_W = 16;
    localparam int GAIN_W   = 8;
    localparam int FREQ_W   = 15;
    localparam int INDEX_W  = 6;
    localparam int INDEX_CMP_W = 9;
    localparam logic [RATE_W-1:0]  RATE_RESET  = 18'd48000;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 20'd89478;
    localparam logic [RATE_W-1:0]  HOLD_STEP   = 18'd8000;

    localparam int NSUM_W = 19;
    localparam int NMAG_W = 18;
    localparam int DRAW_W = 17;
    localparam int QUOT_W = 14;
    localparam logic [NMAG_W-1:0] NOISE_SPAN = 18'd196602;
    localparam logic [15:0] NOISE_RECIP = 16'((64'd1 << 32) / 64'd196602);
    localparam logic [31:0] LFSR_MASK  = 32'h8020_0003;
    localparam logic [31:0] LFSR_RESET = 32'd1;
    localparam int LFSR_STEPS   = 4;
    localparam int NOISE_ROUNDS = 3;

    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 20;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int S_DATA_W   = 72;
    localparam int M_DATA_W   = 40;

    typedef enum logic {
        REG_OUTPUT_RATE = 1'b0,
        REG_PHASE_SCALE = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic tick;
        logic write;
    } seq_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } seq_status_t;

    typedef struct packed {
        logic table_we;
        logic phase_we;
        logic rd_en;
    } vmem_ctl_t;

    typedef struct packed {
        logic [GAIN_W-1:0] gain_right;
        logic [GAIN_W-1:0] gain_left;
        logic              noise;
        logic [FREQ_W-1:0] freq;
    } voice_entry_t;

    function automatic logic [31:0] lfsr_step(input logic [31:0] s);
        return s[0] ? ((s >> 1) ^ LFSR_MASK) : (s >> 1);
    endfunction

    // Quarter-wave sine entry, Q30 Taylor series to the fifteenth power.
    function automatic logic [SINE_W-1:0] quarter_sine(input int k);
        logic [63:0]        x;
        logic [63:0]        term;
        logic [63:0]        prod;
        logic signed [63:0] sum;
        logic [63:0]        q;
        x = (64'(k) * HALF_PI_Q30) / 64'(SINE_ENTRIES);
        term = x;
        sum = $signed(x);
        for (int n = 1; n <= 7; n++) begin
            term = (term * x) >> 30;
            prod = (term * x) >> 30;
            case (n)
                1:       term = prod / 64'd6;
                2:       term = prod / 64'd20;
                3:       term = prod / 64'd42;
                4:       term = prod / 64'd72;
                5:       term = prod / 64'd110;
                6:       term = prod / 64'd156;
                default: term = prod / 64'd210;
            endcase
            if ((n & 1) != 0) begin
                sum = sum - $signed(term);
            end else begin
                sum = sum + $signed(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        q = (64'(sum) * 64'd32767 + 64'd536870912) >> 30;
        if (q > 64'd32767) begin
            q = 64'd32767;
        end
        return q[SINE_W-1:0];
    endfunction

endpackage

// File: design/mvsm_mul.sv
// Shared unsigned multiplier with a registered product.
// Depends on mvsm_pkg for operand widths.
module mvsm_mul (
    input  logic                          aclk,
    input  logic [mvsm_pkg::MUL_A_W-1:0]  mul_a,
    input  logic [mvsm_pkg::MUL_B_W-1:0]  mul_b,
    output logic [mvsm_pkg::MUL_P_W-1:0]  mul_p
);

    logic [mvsm_pkg::MUL_P_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= mvsm_pkg::MUL_P_W'(mul_a) * mvsm_pkg::MUL_P_W'(mul_b);
    end

    assign mul_p = prod_reg;

endmodule

// File: design/mvsm_sine_rom.sv
// Quarter-wave sine table with a registered read port.
// Contents are built at elaboration from mvsm_pkg::quarter_sine.
module mvsm_sine_rom (
    input  logic                           aclk,
    input  logic                           rd_en,
    input  logic [mvsm_pkg::SINE_BITS-1:0] rd_addr,
    output logic [mvsm_pkg::SINE_W-1:0]    rd_data
);

    logic [mvsm_pkg::SINE_W-1:0] rom_w [mvsm_pkg::SINE_ENTRIES];
    logic [mvsm_pkg::SINE_W-1:0] rd_data_reg;

    for (genvar k = 0; k < mvsm_pkg::SINE_ENTRIES; k++) begin : g_rom
        localparam logic [mvsm_pkg::SINE_W-1:0] VALUE = mvsm_pkg::quarter_sine(k);
        assign rom_w[k] = VALUE;
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= rom_w[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: design/mvsm_voice_mem.sv
// Voice entry and phase memories with per-entry valid bits, so that an entry
// never written reads as zero. Depends on mvsm_pkg for the control struct.
module mvsm_voice_mem #(
    parameter  int VOICE_COUNT = mvsm_pkg::VOICE_COUNT_DEF,
    parameter  int PHASE_BITS  = mvsm_pkg::PHASE_BITS_DEF,
    localparam int AW          = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  mvsm_pkg::vmem_ctl_t      ctl,
    input  logic [AW-1:0]            table_addr,
    input  logic [31:0]              table_data,
    input  logic [AW-1:0]            phase_addr,
    input  logic [PHASE_BITS-1:0]    phase_data,
    input  logic [AW-1:0]            rd_addr,
    output logic [31:0]              rd_entry,
    output logic [PHASE_BITS-1:0]    rd_phase
);

    logic [31:0]            table_mem [VOICE_COUNT];
    logic [PHASE_BITS-1:0]  phase_mem [VOICE_COUNT];
    logic [VOICE_COUNT-1:0] table_valid_reg;
    logic [VOICE_COUNT-1:0] phase_valid_reg;
    logic [31:0]            entry_reg;
    logic [PHASE_BITS-1:0]  phase_reg;
    logic                   entry_ok_reg;
    logic                   phase_ok_reg;

    always_ff @(posedge aclk) begin
        if (ctl.table_we) begin
            table_mem[table_addr] <= table_data;
        end
        if (ctl.phase_we) begin
            phase_mem[phase_addr] <= phase_data;
        end
        if (ctl.rd_en) begin
            entry_reg <= table_mem[rd_addr];
            phase_reg <= phase_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            table_valid_reg <= '0;
            phase_valid_reg <= '0;
            entry_ok_reg    <= 1'b0;
            phase_ok_reg    <= 1'b0;
        end else begin
            if (ctl.table_we) begin
                table_valid_reg[table_addr] <= 1'b1;
            end
            if (ctl.phase_we) begin
                phase_valid_reg[phase_addr] <= 1'b1;
            end
            if (ctl.rd_en) begin
                entry_ok_reg <= table_valid_reg[rd_addr];
                phase_ok_reg <= phase_valid_reg[rd_addr];
            end
        end
    end

    assign rd_entry = entry_ok_reg ? entry_reg : '0;
    assign rd_phase = phase_ok_reg ? phase_reg : '0;

endmodule

// File: design/mvsm_seq.sv
// Voice sequencer: walks every voice for a tick request, driving the shared
// multiplier, the sine table and the voice memories. Depends on mvsm_pkg,
// mvsm_mul, mvsm_sine_rom and mvsm_voice_mem.
module mvsm_seq #(
    parameter  int VOICE_COUNT = mvsm_pkg::VOICE_COUNT_DEF,
    parameter  int PHASE_BITS  = mvsm_pkg::PHASE_BITS_DEF,
    localparam int AW          = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  mvsm_pkg::seq_req_t                   req,
    input  logic [mvsm_pkg::INDEX_W-1:0]         voice_index,
    input  logic [mvsm_pkg::FREQ_W-1:0]          voice_frequency,
    input  logic                                 noise_select,
    input  logic [mvsm_pkg::GAIN_W-1:0]          gain_left,
    input  logic [mvsm_pkg::GAIN_W-1:0]          gain_right,
    input  logic [mvsm_pkg::SAMPLE_W-1:0]        base_left,
    input  logic [mvsm_pkg::SAMPLE_W-1:0]        base_right,
    input  logic [mvsm_pkg::SCALE_W-1:0]         phase_scale,
    input  logic                                 out_free,
    output mvsm_pkg::seq_status_t                status,
    output logic [mvsm_pkg::SAMPLE_W-1:0]        mix_left,
    output logic [mvsm_pkg::SAMPLE_W-1:0]        mix_right
);

    localparam int SB = mvsm_pkg::SINE_BITS;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EVAL,
        ST_SINE_STEP,
        ST_SINE_ACC,
        ST_NOISE_DRAW,
        ST_NOISE_CENTRE,
        ST_NOISE_GAIN,
        ST_NOISE_RECIP,
        ST_NOISE_BACK,
        ST_NOISE_FIX,
        ST_FINISH
    } state_t;

    state_t                               state_reg, state_next;
    logic [AW-1:0]                        voice_reg, voice_next;
    logic                                 chan_reg, chan_next;
    logic [mvsm_pkg::SAMPLE_W-1:0]        acc_left_reg, acc_left_next;
    logic [mvsm_pkg::SAMPLE_W-1:0]        acc_right_reg, acc_right_next;
    logic [mvsm_pkg::GAIN_W-1:0]          gl_reg, gl_next;
    logic [mvsm_pkg::GAIN_W-1:0]          gr_reg, gr_next;
    logic [PHASE_BITS-1:0]                phase_reg, phase_next;
    logic                                 sat_reg, sat_next;
    logic                                 neg_reg, neg_next;
    logic [mvsm_pkg::SINE_W-1:0]          mag_reg, mag_next;
    logic [31:0]                          lfsr_reg, lfsr_next;
    logic [1:0]                           round_reg, round_next;
    logic [mvsm_pkg::NSUM_W-1:0]          nsum_reg, nsum_next;
    logic [mvsm_pkg::NMAG_W-1:0]          nmag_reg, nmag_next;
    logic [31:0]                          m_reg, m_next;
    logic [mvsm_pkg::QUOT_W-1:0]          q0_reg, q0_next;

    mvsm_pkg::vmem_ctl_t                  mem_ctl;
    mvsm_pkg::voice_entry_t               entry;
    mvsm_pkg::voice_entry_t               wr_entry;
    logic [31:0]                          rd_entry;
    logic [PHASE_BITS-1:0]                rd_phase;
    logic [AW-1:0]                        rd_addr;
    logic [PHASE_BITS-1:0]                phase_wdata;
    logic                                 rom_en;
    logic [SB-1:0]                        rom_addr;
    logic [mvsm_pkg::SINE_W-1:0]          rom_data;
    logic [mvsm_pkg::MUL_A_W-1:0]         mul_a;
    logic [mvsm_pkg::MUL_B_W-1:0]         mul_b;
    logic [mvsm_pkg::MUL_P_W-1:0]         mul_p;
    logic [SB+1:0]                        sine_pos;
    logic [SB-1:0]                        sine_idx;
    logic                                 silent;
    logic                                 last_voice;
    logic                                 advance;
    logic                                 add_en;
    logic [mvsm_pkg::QUOT_W-1:0]          add_mag;
    logic [mvsm_pkg::SAMPLE_W-1:0]        contrib;
    logic [31:0]                          noise_rem;
    logic [mvsm_pkg::NSUM_W:0]            centred;
    logic [31:0]                          lfsr_walk;
    logic [mvsm_pkg::DRAW_W-1:0]          draw_sum;
    logic                                 in_range;

    mvsm_mul u_mul (
        .aclk  (aclk),
        .mul_a (mul_a),
        .mul_b (mul_b),
        .mul_p (mul_p)
    );

    mvsm_sine_rom u_rom (
        .aclk    (aclk),
        .rd_en   (rom_en),
        .rd_addr (rom_addr),
        .rd_data (rom_data)
    );

    mvsm_voice_mem #(
        .VOICE_COUNT (VOICE_COUNT),
        .PHASE_BITS  (PHASE_BITS)
    ) u_mem (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (mem_ctl),
        .table_addr (AW'(voice_index)),
        .table_data (wr_entry),
        .phase_addr (voice_reg),
        .phase_data (phase_wdata),
        .rd_addr    (rd_addr),
        .rd_entry   (rd_entry),
        .rd_phase   (rd_phase)
    );

    assign entry      = mvsm_pkg::voice_entry_t'(rd_entry);
    assign silent     = (entry.freq == '0) || (entry.gain_left == '0 && entry.gain_right == '0);
    assign last_voice = (voice_reg == AW'(VOICE_COUNT - 1));
    assign sine_pos   = rd_phase[PHASE_BITS-1 -: SB+2];
    assign sine_idx   = sine_pos[SB-1:0];
    assign in_range   = mvsm_pkg::INDEX_CMP_W'(voice_index)
                        < mvsm_pkg::INDEX_CMP_W'(VOICE_COUNT);
    assign phase_wdata = phase_reg + mul_p[PHASE_BITS+9:10];
    assign noise_rem  = m_reg - mul_p[31:0];
    assign centred    = {1'b0, nsum_reg} - {2'b00, mvsm_pkg::NOISE_SPAN};
    assign contrib    = neg_reg ? (mvsm_pkg::SAMPLE_W'(0) - mvsm_pkg::SAMPLE_W'(add_mag))
                                : mvsm_pkg::SAMPLE_W'(add_mag);

    always_comb begin
        wr_entry.freq       = voice_frequency;
        wr_entry.noise      = noise_select;
        wr_entry.gain_left  = gain_left;
        wr_entry.gain_right = gain_right;
    end

    // Four Galois steps of the noise register per cycle.
    always_comb begin
        lfsr_walk = lfsr_reg;
        draw_sum  = '0;
        for (int i = 0; i < mvsm_pkg::LFSR_STEPS; i++) begin
            lfsr_walk = mvsm_pkg::lfsr_step(lfsr_walk);
            draw_sum  = draw_sum + mvsm_pkg::DRAW_W'(lfsr_walk[14:0]);
        end
    end

    always_comb begin
        state_next     = state_reg;
        voice_next     = voice_reg;
        chan_next      = chan_reg;
        acc_left_next  = acc_left_reg;
        acc_right_next = acc_right_reg;
        gl_next        = gl_reg;
        gr_next        = gr_reg;
        phase_next     = phase_reg;
        sat_next       = sat_reg;
        neg_next       = neg_reg;
        mag_next       = mag_reg;
        lfsr_next      = lfsr_reg;
        round_next     = round_reg;
        nsum_next      = nsum_reg;
        nmag_next      = nmag_reg;
        m_next         = m_reg;
        q0_next        = q0_reg;
        mem_ctl        = '0;
        rd_addr        = voice_reg + AW'(1);
        rom_en         = 1'b0;
        rom_addr       = sine_pos[SB] ? (SB'(0) - sine_idx) : sine_idx;
        mul_a          = '0;
        mul_b          = '0;
        advance        = 1'b0;
        add_en         = 1'b0;
        add_mag        = '0;
        status.busy    = (state_reg != ST_IDLE);
        status.done    = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (req.write && in_range) begin
                    mem_ctl.table_we = 1'b1;
                end
                if (req.tick) begin
                    acc_left_next  = base_left;
                    acc_right_next = base_right;
                    voice_next     = '0;
                    rd_addr        = '0;
                    mem_ctl.rd_en  = 1'b1;
                    state_next     = ST_EVAL;
                end
            end
            ST_EVAL: begin
                gl_next    = entry.gain_left;
                gr_next    = entry.gain_right;
                phase_next = rd_phase;
                if (silent) begin
                    advance = 1'b1;
                end else if (entry.noise) begin
                    round_next = '0;
                    nsum_next  = '0;
                    state_next = ST_NOISE_DRAW;
                end else begin
                    rom_en     = 1'b1;
                    sat_next   = sine_pos[SB] && (sine_idx == '0);
                    neg_next   = sine_pos[SB+1];
                    mul_a      = mvsm_pkg::MUL_A_W'(entry.freq);
                    mul_b      = phase_scale;
                    state_next = ST_SINE_STEP;
                end
            end
            ST_SINE_STEP: begin
                mag_next         = sat_reg ? mvsm_pkg::SINE_FULL : rom_data;
                mem_ctl.phase_we = 1'b1;
                mul_a            = mvsm_pkg::MUL_A_W'(sat_reg ? mvsm_pkg::SINE_FULL : rom_data);
                mul_b            = mvsm_pkg::MUL_B_W'(gl_reg);
                chan_next        = 1'b0;
                state_next       = ST_SINE_ACC;
            end
            ST_SINE_ACC: begin
                add_en  = 1'b1;
                add_mag = mul_p[mvsm_pkg::SINE_SHIFT +: mvsm_pkg::QUOT_W];
                if (!chan_reg) begin
                    mul_a     = mvsm_pkg::MUL_A_W'(mag_reg);
                    mul_b     = mvsm_pkg::MUL_B_W'(gr_reg);
                    chan_next = 1'b1;
                end else begin
                    advance = 1'b1;
                end
            end
            ST_NOISE_DRAW: begin
                lfsr_next  = lfsr_walk;
                nsum_next  = nsum_reg + mvsm_pkg::NSUM_W'(draw_sum);
                round_next = round_reg + 2'd1;
                if (round_reg == 2'(mvsm_pkg::NOISE_ROUNDS - 1)) begin
                    state_next = ST_NOISE_CENTRE;
                end
            end
            ST_NOISE_CENTRE: begin
                neg_next   = centred[mvsm_pkg::NSUM_W];
                nmag_next  = centred[mvsm_pkg::NSUM_W]
                             ? mvsm_pkg::NMAG_W'(~centred + 1'b1)
                             : mvsm_pkg::NMAG_W'(centred);
                chan_next  = 1'b0;
                state_next = ST_NOISE_GAIN;
            end
            ST_NOISE_GAIN: begin
                mul_a      = mvsm_pkg::MUL_A_W'(nmag_reg);
                mul_b      = mvsm_pkg::MUL_B_W'(chan_reg ? gr_reg : gl_reg);
                state_next = ST_NOISE_RECIP;
            end
            ST_NOISE_RECIP: begin
                m_next     = {mul_p[25:0], 6'b000000};
                mul_a      = {mul_p[25:0], 6'b000000};
                mul_b      = mvsm_pkg::MUL_B_W'(mvsm_pkg::NOISE_RECIP);
                state_next = ST_NOISE_BACK;
            end
            ST_NOISE_BACK: begin
                q0_next    = mul_p[32 +: mvsm_pkg::QUOT_W];
                mul_a      = mvsm_pkg::MUL_A_W'(mul_p[32 +: mvsm_pkg::QUOT_W]);
                mul_b      = mvsm_pkg::MUL_B_W'(mvsm_pkg::NOISE_SPAN);
                state_next = ST_NOISE_FIX;
            end
            ST_NOISE_FIX: begin
                add_en  = 1'b1;
                add_mag = q0_reg + mvsm_pkg::QUOT_W'(noise_rem >= 32'(mvsm_pkg::NOISE_SPAN));
                if (!chan_reg) begin
                    chan_next  = 1'b1;
                    state_next = ST_NOISE_GAIN;
                end else begin
                    advance = 1'b1;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    status.done = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (add_en) begin
            if (chan_reg) begin
                acc_right_next = acc_right_reg + contrib;
            end else begin
                acc_left_next = acc_left_reg + contrib;
            end
        end

        if (advance) begin
            if (last_voice) begin
                state_next = ST_FINISH;
            end else begin
                voice_next    = voice_reg + AW'(1);
                mem_ctl.rd_en = 1'b1;
                state_next    = ST_EVAL;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            lfsr_reg  <= mvsm_pkg::LFSR_RESET;
            round_reg <= '0;
            chan_reg  <= 1'b0;
            voice_reg <= '0;
        end else begin
            state_reg     <= state_next;
            lfsr_reg      <= lfsr_next;
            round_reg     <= round_next;
            chan_reg      <= chan_next;
            voice_reg     <= voice_next;
            acc_left_reg  <= acc_left_next;
            acc_right_reg <= acc_right_next;
            gl_reg        <= gl_next;
            gr_reg        <= gr_next;
            phase_reg     <= phase_next;
            sat_reg       <= sat_next;
            neg_reg       <= neg_next;
            mag_reg       <= mag_next;
            nsum_reg      <= nsum_next;
            nmag_reg      <= nmag_next;
            m_reg         <= m_next;
            q0_reg        <= q0_next;
        end
    end

    assign mix_left  = acc_left_reg;
    assign mix_right = acc_right_reg;

    a_req_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (req.tick || req.write) |-> state_reg == ST_IDLE)
        else $error("Request presented while the sequencer is busy.");

    a_tick_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        req.tick |=> state_reg == ST_EVAL)
        else $error("Tick request did not start the voice walk.");

    a_draw_count: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_NOISE_CENTRE |-> round_reg == 2'(mvsm_pkg::NOISE_ROUNDS))
        else $error("Wrong number of noise draw rounds.");

    a_recip_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_NOISE_FIX |-> noise_rem < 32'(2 * mvsm_pkg::NOISE_SPAN))
        else $error("Reciprocal quotient estimate is off by more than one.");

    a_chan_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_NOISE_FIX && !chan_reg) |=> (state_reg == ST_NOISE_GAIN && chan_reg))
        else $error("Right channel of a noise voice was skipped.");

endmodule

// File: design/multi_voice_sine_noise_mixer_unit.sv
// Top level of the multi-voice sine and noise mixer: stream ports, register
// port, sample-hold accumulator and output register. Depends on mvsm_pkg and mvsm_seq.
//
// The input stream carries two kinds of request, told apart by s_tuser. A
// write request (s_tuser = 1) loads one voice entry; an index beyond the
// voice count is dropped. A tick request (s_tuser = 0) produces one stereo
// sample on the output stream. On a tick the 8 kHz stream pair in s_tdata
// is latched when the hold accumulator calls for it, and then the sequencer
// walks every voice through one shared multiplier: a silent voice is skipped,
// a sine voice takes a table read, a phase step and two gain products, and a
// noise voice takes a noise draw, then a gain and divide for each channel.
// The walk ends in a finish state that stores the result in the output register. While a tick is
// being worked on s_tready is low. If the receiver stalls, the finished
// sample waits in the output register; the next tick is accepted and worked
// on, and only its final store waits for that register to drain.
// After reset all voices are silent with zero phase, the held pair is zero,
// the noise register is one and both configuration registers hold their
// defaults; the block is ready once reset is released.
module multi_voice_sine_noise_mixer_unit #(
    parameter int VOICE_COUNT = mvsm_pkg::VOICE_COUNT_DEF,
    parameter int PHASE_BITS  = mvsm_pkg::PHASE_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // voice_index, voice_frequency, noise_select, gain_left, gain_right,
    // stream_left, stream_right, two zero bits
    input  logic [mvsm_pkg::S_DATA_W-1:0]        s_tdata,
    // action
    input  logic                                 s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // mix_left, mix_right, stream_taken, seven zero bits
    output logic [mvsm_pkg::M_DATA_W-1:0]        m_tdata,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [mvsm_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [mvsm_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [mvsm_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                 pready
);

    logic [mvsm_pkg::RATE_W-1:0]   rate_reg;
    logic [mvsm_pkg::SCALE_W-1:0]  scale_reg;
    logic [mvsm_pkg::RATE_W-1:0]   hold_reg;
    logic [mvsm_pkg::RATE_W-1:0]   hold_base;
    logic [mvsm_pkg::SAMPLE_W-1:0] held_left_reg;
    logic [mvsm_pkg::SAMPLE_W-1:0] held_right_reg;
    logic [mvsm_pkg::SAMPLE_W-1:0] base_left;
    logic [mvsm_pkg::SAMPLE_W-1:0] base_right;
    logic                          taken_reg;
    logic                          hold_due;
    logic                          m_valid_reg;
    logic [mvsm_pkg::M_DATA_W-1:0] m_data_reg;
    logic                          in_accept;
    logic                          cfg_write;
    logic                          out_free;
    mvsm_pkg::cfg_reg_t            cfg_sel;
    mvsm_pkg::seq_req_t            req;
    mvsm_pkg::seq_status_t         status;
    logic [mvsm_pkg::SAMPLE_W-1:0] mix_left;
    logic [mvsm_pkg::SAMPLE_W-1:0] mix_right;

    assign pready    = 1'b1;
    assign cfg_sel   = mvsm_pkg::cfg_reg_t'(paddr[2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        case (cfg_sel)
            mvsm_pkg::REG_OUTPUT_RATE: prdata = mvsm_pkg::APB_DATA_W'(rate_reg);
            mvsm_pkg::REG_PHASE_SCALE: prdata = mvsm_pkg::APB_DATA_W'(scale_reg);
            default:                   prdata = '0;
        endcase
    end

    assign s_tready  = !status.busy;
    assign in_accept = s_tvalid && s_tready;
    assign req.tick  = in_accept && !s_tuser;
    assign req.write = in_accept && s_tuser;

    assign hold_due   = (hold_reg >= rate_reg);
    assign hold_base  = hold_due ? (hold_reg - rate_reg) : hold_reg;
    assign base_left  = hold_due ? s_tdata[53:38] : held_left_reg;
    assign base_right = hold_due ? s_tdata[69:54] : held_right_reg;
    assign out_free   = !m_valid_reg || m_tready;

    mvsm_seq #(
        .VOICE_COUNT (VOICE_COUNT),
        .PHASE_BITS  (PHASE_BITS)
    ) u_seq (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .req             (req),
        .voice_index     (s_tdata[5:0]),
        .voice_frequency (s_tdata[20:6]),
        .noise_select    (s_tdata[21]),
        .gain_left       (s_tdata[29:22]),
        .gain_right      (s_tdata[37:30]),
        .base_left       (base_left),
        .base_right      (base_right),
        .phase_scale     (scale_reg),
        .out_free        (out_free),
        .status          (status),
        .mix_left        (mix_left),
        .mix_right       (mix_right)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_reg       <= mvsm_pkg::RATE_RESET;
            scale_reg      <= mvsm_pkg::SCALE_RESET;
            hold_reg       <= mvsm_pkg::RATE_RESET;
            held_left_reg  <= '0;
            held_right_reg <= '0;
            taken_reg      <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_write) begin
                case (cfg_sel)
                    mvsm_pkg::REG_OUTPUT_RATE: rate_reg <= pwdata[mvsm_pkg::RATE_W-1:0];
                    mvsm_pkg::REG_PHASE_SCALE: scale_reg <= pwdata[mvsm_pkg::SCALE_W-1:0];
                    default: ;
                endcase
            end
            if (req.tick) begin
                hold_reg       <= hold_base + mvsm_pkg::HOLD_STEP;
                held_left_reg  <= base_left;
                held_right_reg <= base_right;
                taken_reg      <= hold_due;
            end
            if (status.done) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (status.done) begin
            m_data_reg <= {7'b0000000, taken_reg, mix_right, mix_left};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// File: bench/multi_voice_sine_noise_mixer_unit_tb.sv
// Self-checking bench for multi_voice_sine_noise_mixer_unit: voice writes and sample ticks
// are driven on the input stream and both configuration registers are set per phase, while
// a cycle-free model predicts every output sample. Depends on mvsm_pkg and the mixer RTL only.
`timescale 1ns / 1ps

module multi_voice_sine_noise_mixer_unit_tb;

    typedef enum logic {
        ACT_TICK  = 1'b0,
        ACT_WRITE = 1'b1
    } synth_act_t;

    typedef struct {
        synth_act_t  action;
        logic [5:0]  vidx;
        logic [14:0] freq;
        logic        noise;
        logic [7:0]  gain_l;
        logic [7:0]  gain_r;
        logic [15:0] stream_l;
        logic [15:0] stream_r;
    } synth_req_t;

    typedef struct {
        logic [14:0] freq;
        logic        noise;
        logic [7:0]  gain_l;
        logic [7:0]  gain_r;
    } voice_slot_t;

    typedef struct {
        logic [15:0] mix_l;
        logic [15:0] mix_r;
        logic        taken;
    } mix_sample_t;

    localparam int          VOICES        = 64;
    localparam int          SINE_SIZE     = 1024;
    localparam logic [17:0] HOLD_INC      = 18'd8000;
    localparam logic [31:0] LFSR_TAPS     = 32'h8020_0003;
    localparam longint      NOISE_DIVISOR = 196602;
    localparam int          SETTLE_CYCLES = 20;
    localparam int          WATCHDOG_MAX  = 5000;
    localparam int          PHASES        = 8;
    localparam int          ITEMS_PER_PHASE = 210;

    logic aclk;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [mvsm_pkg::S_DATA_W-1:0] s_tdata = '0;
    logic s_tuser = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [mvsm_pkg::M_DATA_W-1:0] m_tdata;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [mvsm_pkg::APB_ADDR_W-1:0] paddr = '0;
    logic [mvsm_pkg::APB_DATA_W-1:0] pwdata = '0;
    logic [mvsm_pkg::APB_DATA_W-1:0] prdata;
    logic pready;

    multi_voice_sine_noise_mixer_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Mixer model state.
    logic [17:0] rate_reg;
    logic [19:0] scale_reg;
    voice_slot_t voice_cfg [VOICES];
    logic [23:0] voice_ph [VOICES];
    logic [15:0] held_l;
    logic [15:0] held_r;
    logic [17:0] hold_acc;
    logic [31:0] noise_reg;
    int          sine_q [SINE_SIZE];

    synth_req_t  pending_reqs [$];
    mix_sample_t expected_mix [$];
    synth_req_t  cur_req;
    int          fail_count = 0;
    int          sample_count = 0;
    int          gap_left = 0;
    int          stall_left = 0;
    int          quiet_cycles = 0;
    bit          steady_run [2];
    mix_sample_t got_mix;
    mix_sample_t want_mix;

    int unsigned rate_plan [PHASES] = '{8000, 192000, 262143, 44100, 5000, 0, 96000, 48000};
    int unsigned scale_plan [PHASES] = '{536871, 22370, 1048575, 97391, 0, 12345, 44739,
                                         89478};

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Quarter-wave entry from a Q30 Taylor series with truncating steps.
    function automatic int sine_entry(input int k);
        logic [63:0] x;
        logic [63:0] term;
        longint      acc;
        logic [63:0] q;
        x = (64'(k) * 64'd1686629713) / 64'(SINE_SIZE);
        term = x;
        acc = longint'(x);
        for (int n = 1; n <= 7; n++) begin
            term = (term * x) >> 30;
            term = ((term * x) >> 30) / 64'((2 * n) * (2 * n + 1));
            if ((n % 2) == 1) begin
                acc = acc - longint'(term);
            end else begin
                acc = acc + longint'(term);
            end
        end
        if (acc < 0) begin
            acc = 0;
        end
        q = (64'(acc) * 64'd32767 + 64'd536870912) >> 30;
        if (q > 64'd32767) begin
            q = 64'd32767;
        end
        return int'(q);
    endfunction

    function automatic void model_reset();
        rate_reg = 18'd48000;
        scale_reg = 20'd89478;
        for (int v = 0; v < VOICES; v++) begin
            voice_cfg[v] = '{15'd0, 1'b0, 8'd0, 8'd0};
            voice_ph[v] = '0;
        end
        held_l = '0;
        held_r = '0;
        hold_acc = rate_reg;
        noise_reg = 32'd1;
        for (int k = 0; k < SINE_SIZE; k++) begin
            sine_q[k] = sine_entry(k);
        end
    endfunction

    function automatic int table_sine(input logic [23:0] ph);
        logic [1:0] quad;
        logic [9:0] idx;
        int         s;
        quad = ph[23:22];
        idx = ph[21:12];
        if (quad[0]) begin
            s = (idx == 10'd0) ? 32767 : sine_q[SINE_SIZE - int'(idx)];
        end else begin
            s = sine_q[idx];
        end
        return quad[1] ? -s : s;
    endfunction

    function automatic mix_sample_t mix_tick(input synth_req_t r);
        mix_sample_t o;
        int          gl;
        int          gr;
        int          s;
        int          cl;
        int          cr;
        longint      n;
        logic [63:0] stp;
        o.taken = 1'b0;
        if (hold_acc >= rate_reg) begin
            hold_acc = hold_acc - rate_reg;
            held_l = r.stream_l;
            held_r = r.stream_r;
            o.taken = 1'b1;
        end
        o.mix_l = held_l;
        o.mix_r = held_r;
        hold_acc = hold_acc + HOLD_INC;
        for (int v = 0; v < VOICES; v++) begin
            gl = int'(voice_cfg[v].gain_l) * 64;
            gr = int'(voice_cfg[v].gain_r) * 64;
            if (voice_cfg[v].freq != 15'd0 && (gl != 0 || gr != 0)) begin
                if (voice_cfg[v].noise) begin
                    n = 0;
                    for (int u = 0; u < 12; u++) begin
                        noise_reg = noise_reg[0] ? ((noise_reg >> 1) ^ LFSR_TAPS)
                                                 : (noise_reg >> 1);
                        n = n + longint'(noise_reg[14:0]);
                    end
                    n = n - NOISE_DIVISOR;
                    cl = int'((n * longint'(gl)) / NOISE_DIVISOR);
                    cr = int'((n * longint'(gr)) / NOISE_DIVISOR);
                end else begin
                    s = table_sine(voice_ph[v]);
                    stp = (64'(voice_cfg[v].freq) * 64'(scale_reg)) >> 10;
                    cl = (s * gl) / 32768;
                    cr = (s * gr) / 32768;
                    voice_ph[v] = voice_ph[v] + stp[23:0];
                end
                o.mix_l = o.mix_l + cl[15:0];
                o.mix_r = o.mix_r + cr[15:0];
            end
        end
        return o;
    endfunction

    // Input data from bit 0 up: voice index, frequency, noise select, left gain,
    // right gain, left stream sample, right stream sample, two zero bits.
    function automatic logic [mvsm_pkg::S_DATA_W-1:0] pack_req(input synth_req_t r);
        return {2'b00, r.stream_r, r.stream_l, r.gain_r, r.gain_l, r.noise, r.freq, r.vidx};
    endfunction

    function automatic int pick_idle(input int side);
        if ($urandom_range(0, 63) == 0) begin
            steady_run[side] = !steady_run[side];
        end
        if (steady_run[side]) begin
            return 0;
        end
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return 0;
            5, 6, 7, 8:    return $urandom_range(1, 4);
            default:       return $urandom_range(10, 40);
        endcase
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: sample %0d %s mismatch, expected %0d, got %0d",
                     $time, sample_count, name, want, got);
            fail_count++;
        end
    endtask

    // Request driver: presents queued requests and feeds each accepted one to the model.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            gap_left = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                if (cur_req.action == ACT_WRITE) begin
                    voice_cfg[cur_req.vidx] = '{cur_req.freq, cur_req.noise,
                                                cur_req.gain_l, cur_req.gain_r};
                end else begin
                    expected_mix.push_back(mix_tick(cur_req));
                end
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (pending_reqs.size() != 0) begin
                    cur_req = pending_reqs.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= pack_req(cur_req);
                    s_tuser <= cur_req.action;
                    gap_left = pick_idle(0);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Sample monitor with random back-pressure.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got_mix.mix_l = m_tdata[15:0];
                got_mix.mix_r = m_tdata[31:16];
                got_mix.taken = m_tdata[32];
                if (expected_mix.size() == 0) begin
                    $display("%0t: unexpected sample, expected none, got %0d %0d %0d", $time,
                             $signed(got_mix.mix_l), $signed(got_mix.mix_r), got_mix.taken);
                    fail_count++;
                end else begin
                    want_mix = expected_mix.pop_front();
                    check_field("mix_left", int'($signed(want_mix.mix_l)),
                                int'($signed(got_mix.mix_l)));
                    check_field("mix_right", int'($signed(want_mix.mix_r)),
                                int'($signed(got_mix.mix_r)));
                    check_field("stream_taken", int'(want_mix.taken), int'(got_mix.taken));
                end
                sample_count++;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                stall_left = pick_idle(1);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_MAX) begin
            $display("multi_voice_sine_noise_mixer_unit_tb: FAIL");
            $finish;
        end
    end

    function automatic synth_req_t random_fields(input synth_act_t act);
        synth_req_t r;
        r.action = act;
        r.vidx = 6'($urandom_range(0, VOICES - 1));
        case ($urandom_range(0, 9))
            0, 1:    r.freq = 15'd0;
            2:       r.freq = 15'h7FFF;
            3:       r.freq = 15'($urandom_range(1, 16));
            default: r.freq = 15'($urandom_range(1, 32767));
        endcase
        r.noise = ($urandom_range(0, 4) < 2);
        r.gain_l = ($urandom_range(0, 6) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
        r.gain_r = ($urandom_range(0, 6) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
        if ($urandom_range(0, 9) == 0) begin
            r.gain_l = 8'hFF;
        end
        r.stream_l = 16'($urandom);
        r.stream_r = 16'($urandom);
        return r;
    endfunction

    task automatic push_write(input int idx, input int freq, input bit noise,
                              input int gl, input int gr);
        synth_req_t r;
        r = random_fields(ACT_WRITE);
        r.vidx = 6'(idx);
        r.freq = 15'(freq);
        r.noise = noise;
        r.gain_l = 8'(gl);
        r.gain_r = 8'(gr);
        pending_reqs.push_back(r);
    endtask

    task automatic push_tick(input int sl, input int sr);
        synth_req_t r;
        r = random_fields(ACT_TICK);
        r.stream_l = 16'(sl);
        r.stream_r = 16'(sr);
        pending_reqs.push_back(r);
    endtask

    // A short burst of voice writes, then mostly ticks with the odd voice change.
    task automatic push_random(input int count);
        int burst;
        burst = $urandom_range(2, 8);
        for (int i = 0; i < count; i++) begin
            if (i < burst || $urandom_range(0, 3) == 0) begin
                pending_reqs.push_back(random_fields(ACT_WRITE));
            end else begin
                pending_reqs.push_back(random_fields(ACT_TICK));
            end
        end
    endtask

    task automatic drain();
        do begin
            @(negedge aclk);
        end while (pending_reqs.size() != 0 || s_tvalid || expected_mix.size() != 0);
    endtask

    task automatic reg_write(input mvsm_pkg::cfg_reg_t which, input logic [31:0] value);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {which, 2'b00};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (which == mvsm_pkg::REG_OUTPUT_RATE) begin
            rate_reg = value[17:0];
        end else begin
            scale_reg = value[19:0];
        end
    endtask

    initial begin
        model_reset();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        push_write(0, 32767, 1'b0, 255, 255);
        push_write(63, 1, 1'b1, 255, 0);
        push_write(1, 100, 1'b0, 0, 0);
        push_write(2, 0, 1'b0, 200, 200);
        push_write(5, 32767, 1'b1, 0, 255);
        push_write(42, 1, 1'b0, 1, 128);
        push_tick(32767, -32768);
        push_tick(-32768, 32767);
        push_tick(0, -1);
        push_tick(-1, 0);
        push_tick(12345, -12345);
        push_tick(32767, 32767);
        push_tick(-32768, -32768);
        push_write(0, 0, 1'b0, 255, 255);
        push_write(63, 32767, 1'b1, 255, 255);
        push_write(7, 16384, 1'b0, 255, 1);
        push_tick(100, 200);
        push_tick(-100, -200);
        push_tick(32767, -32768);
        push_tick(0, 0);
        push_tick(-32768, 32767);
        push_tick(1, -1);
        push_tick(32767, 32767);
        push_tick(-32768, -32768);
        drain();

        for (int p = 0; p < PHASES; p++) begin
            repeat (SETTLE_CYCLES) @(posedge aclk);
            reg_write(mvsm_pkg::REG_OUTPUT_RATE, rate_plan[p]);
            reg_write(mvsm_pkg::REG_PHASE_SCALE, scale_plan[p]);
            push_random(ITEMS_PER_PHASE / 2);
            drain();
            push_random(ITEMS_PER_PHASE - ITEMS_PER_PHASE / 2);
            drain();
        end

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("multi_voice_sine_noise_mixer_unit_tb: PASS");
        end else begin
            $display("multi_voice_sine_noise_mixer_unit_tb: FAIL");
        end
        $finish;
    end

endmodule

// File: filelist.f
design/mvsm_pkg.sv
design/mvsm_mul.sv
design/mvsm_sine_rom.sv
design/mvsm_voice_mem.sv
design/mvsm_seq.sv
design/multi_voice_sine_noise_mixer_unit.sv
bench/multi_voice_sine_noise_mixer_unit_tb.sv
